/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RTPNAL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// consequence that must hold at the next clock edge after the cause
`define RTPNAL_ASSERT_NEXT(label, clk, rst_n, cause, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rtpnal_pkg.sv */
// types, constants and helpers shared by the nal reassembler modules
package rtpnal_pkg;

	localparam int OFFSET_BITS_DEFAULT = 16;
	localparam int LEN_W = 16;
	localparam int TS_W = 32;
	localparam int TYPE_W = 5;
	localparam int MAX_RESULTS = 3;
	localparam int COUNT_W = 2;
	localparam int QUEUE_AW = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [TYPE_W-1:0] TYPE_STAP_A = 5'd24;
	localparam logic [TYPE_W-1:0] TYPE_STAP_B = 5'd25;
	localparam logic [TYPE_W-1:0] TYPE_MTAP24 = 5'd27;
	localparam logic [TYPE_W-1:0] TYPE_FU_A = 5'd28;
	localparam logic [TYPE_W-1:0] TYPE_FU_B = 5'd29;

	localparam int FU_START_BIT = 7;
	localparam int FU_END_BIT = 6;

	localparam logic [1:0] SKIP_NONE = 2'd0;
	localparam logic [1:0] SKIP_STAP_A = 2'd1;
	localparam logic [1:0] SKIP_FU = 2'd2;
	localparam logic [1:0] SKIP_LONG = 2'd3;

	typedef enum logic [1:0] {
		EV_STORE = 2'd0,
		EV_COMPLETE = 2'd1,
		EV_DROP = 2'd2,
		EV_ERROR = 2'd3
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [LEN_W-1:0] addr;
		logic [7:0] data;
		logic [LEN_W-1:0] len;
		logic [TS_W-1:0] ts;
		logic [TYPE_W-1:0] typ;
	} event_t;

	typedef struct packed {
		event_t [MAX_RESULTS-1:0] ev;
		logic [COUNT_W-1:0] count;
	} bundle_t;

	function automatic logic is_fu(logic [TYPE_W-1:0] t);
		return (t == TYPE_FU_A) || (t == TYPE_FU_B);
	endfunction

	function automatic logic [1:0] skip_for(logic [TYPE_W-1:0] t);
		logic [1:0] s;
		if (t == TYPE_STAP_A) begin
			s = SKIP_STAP_A;
		end else if (t >= TYPE_STAP_B && t <= TYPE_MTAP24) begin
			s = SKIP_LONG;
		end else begin
			s = SKIP_NONE;
		end
		return s;
	endfunction

	function automatic bundle_t push_event(bundle_t b, event_t e);
		if (b.count < COUNT_W'(MAX_RESULTS)) begin
			b.ev[b.count] = e;
			b.count = b.count + 1'b1;
		end
		return b;
	endfunction

endpackage

/* rtl/rtpnal_front.sv */
// front part: accepts payload bytes, tracks packet and nal state, builds event bundles
module rtpnal_front import rtpnal_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  logic [7:0]        payload_byte,
	input  logic              packet_start,
	input  logic              packet_end,
	input  logic [LEN_W-1:0]  packet_length,
	input  logic [TS_W-1:0]   rtp_timestamp,
	input  logic              cfg_valid,
	input  logic [LEN_W-1:0]  cfg_data,
	output logic              push_valid,
	output bundle_t           push_bundle
);

	localparam int CW = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
	localparam logic [CW-1:0] OFFSET_MAX = CW'((1 << OFFSET_BITS) - 1);

	typedef struct packed {
		logic                   open;
		logic [OFFSET_BITS-1:0] wo;
		logic [TS_W-1:0]        hts;
		logic                   disc;
		logic [TYPE_W-1:0]      ctype;
		bundle_t                bnd;
	} work_t;

	logic                   nal_open_q;
	logic [OFFSET_BITS-1:0] write_offset_q;
	logic [TS_W-1:0]        held_ts_q;
	logic [LEN_W-1:0]       byte_pos_q;
	logic [TYPE_W-1:0]      packet_kind_q;
	logic [1:0]             skip_count_q;
	logic [2:0]             indicator_q;
	logic                   completes_q;
	logic                   discard_q;
	logic [TYPE_W-1:0]      current_type_q;
	logic [LEN_W-1:0]       capacity_q;

	logic [CW-1:0]          cap_limit;
	work_t                  w_nxt;
	logic [LEN_W-1:0]       pos_nxt;
	logic [TYPE_W-1:0]      pk_nxt;
	logic [1:0]             skip_nxt;
	logic [2:0]             ind_nxt;
	logic                   comp_nxt;
	logic                   accept;

	function automatic work_t f_emit(work_t w, event_kind_t k, logic [OFFSET_BITS-1:0] addr,
			logic [7:0] data, logic [OFFSET_BITS-1:0] len, logic [TS_W-1:0] ts);
		event_t e;
		e.kind = k;
		e.addr = LEN_W'(addr);
		e.data = data;
		e.len = LEN_W'(len);
		e.ts = ts;
		e.typ = w.ctype;
		w.bnd = push_event(w.bnd, e);
		return w;
	endfunction

	function automatic work_t f_drop(work_t w, event_kind_t k);
		w = f_emit(w, k, '0, '0, w.open ? w.wo : '0, w.open ? w.hts : '0);
		w.open = 1'b0;
		return w;
	endfunction

	function automatic work_t f_open(work_t w, logic [TS_W-1:0] ts);
		if (!w.open || w.hts != ts) begin
			if (w.open) begin
				w = f_drop(w, EV_DROP);
			end
			w.open = 1'b1;
			w.wo = '0;
		end
		w.hts = ts;
		return w;
	endfunction

	function automatic work_t f_room(work_t w, logic [LEN_W-1:0] need, logic [CW-1:0] cap);
		logic [CW-1:0] room;
		room = (cap > CW'(w.wo)) ? cap - CW'(w.wo) : '0;
		if (CW'(need) > room) begin
			w = f_drop(w, EV_DROP);
			w.disc = 1'b1;
		end
		return w;
	endfunction

	function automatic work_t f_store(work_t w, logic [7:0] x, logic [CW-1:0] cap);
		if (w.open && !w.disc) begin
			if (CW'(w.wo) >= cap) begin
				w = f_drop(w, EV_DROP);
				w.disc = 1'b1;
			end else begin
				w = f_emit(w, EV_STORE, w.wo, x, '0, '0);
				w.wo = w.wo + 1'b1;
			end
		end
		return w;
	endfunction

	assign accept = item_valid && item_ready;
	assign cap_limit = (CW'(capacity_q) < OFFSET_MAX) ? CW'(capacity_q) : OFFSET_MAX;

	always_comb begin
		work_t w;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] need;
		logic [LEN_W-1:0] hdr;
		w.open = nal_open_q;
		w.wo = write_offset_q;
		w.hts = held_ts_q;
		w.disc = discard_q;
		w.ctype = current_type_q;
		w.bnd = '0;
		pos = packet_start ? '0 : byte_pos_q;
		pk_nxt = packet_kind_q;
		skip_nxt = skip_count_q;
		ind_nxt = indicator_q;
		comp_nxt = completes_q;
		need = '0;
		hdr = '0;
		if (pos == '0) begin
			w.disc = 1'b0;
			comp_nxt = 1'b0;
			pk_nxt = payload_byte[TYPE_W-1:0];
			if (is_fu(pk_nxt)) begin
				ind_nxt = payload_byte[7:5];
				skip_nxt = SKIP_FU;
				if (packet_length < LEN_W'(2) || packet_end) begin
					w = f_drop(w, EV_ERROR);
					w.disc = 1'b1;
				end else begin
					w = f_open(w, rtp_timestamp);
				end
			end else begin
				skip_nxt = skip_for(pk_nxt);
				w = f_open(w, rtp_timestamp);
				w.ctype = pk_nxt;
				comp_nxt = 1'b1;
				need = (packet_length > LEN_W'(skip_nxt)) ?
					packet_length - LEN_W'(skip_nxt) : '0;
				w = f_room(w, need, cap_limit);
				if (!w.disc && skip_nxt == SKIP_NONE) begin
					w = f_store(w, payload_byte, cap_limit);
				end
			end
		end else if (is_fu(pk_nxt) && pos == LEN_W'(1)) begin
			if (!w.disc) begin
				hdr = payload_byte[FU_START_BIT] ? LEN_W'(1) : LEN_W'(2);
				need = (packet_length > hdr) ? packet_length - hdr : '0;
				comp_nxt = payload_byte[FU_END_BIT];
				w.ctype = payload_byte[TYPE_W-1:0];
				w = f_room(w, need, cap_limit);
				if (!w.disc && payload_byte[FU_START_BIT]) begin
					w = f_store(w, {ind_nxt, payload_byte[TYPE_W-1:0]}, cap_limit);
				end
			end
		end else if (pos >= LEN_W'(skip_nxt)) begin
			w = f_store(w, payload_byte, cap_limit);
		end
		if (packet_end) begin
			if (!w.disc && w.open && comp_nxt) begin
				w = f_emit(w, EV_COMPLETE, '0, '0, w.wo, w.hts);
				w.open = 1'b0;
			end
			pos_nxt = '0;
		end else begin
			pos_nxt = (pos != '1) ? pos + 1'b1 : pos;
		end
		w_nxt = w;
	end

	assign push_valid = accept && (w_nxt.bnd.count != '0);
	assign push_bundle = w_nxt.bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_open_q <= 1'b0;
			write_offset_q <= '0;
			held_ts_q <= '0;
			byte_pos_q <= '0;
			packet_kind_q <= '0;
			skip_count_q <= '0;
			indicator_q <= '0;
			completes_q <= 1'b0;
			discard_q <= 1'b0;
			current_type_q <= '0;
		end else if (accept) begin
			nal_open_q <= w_nxt.open;
			write_offset_q <= w_nxt.wo;
			held_ts_q <= w_nxt.hts;
			byte_pos_q <= pos_nxt;
			packet_kind_q <= pk_nxt;
			skip_count_q <= skip_nxt;
			indicator_q <= ind_nxt;
			completes_q <= comp_nxt;
			discard_q <= w_nxt.disc;
			current_type_q <= w_nxt.ctype;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '1;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

endmodule

/* rtl/rtpnal_queue.sv */
// short queue of event bundles between the front and back parts
module rtpnal_queue import rtpnal_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  bundle_t push_bundle,
	output logic    full,
	input  logic    pop,
	output bundle_t head,
	output logic    head_valid
);

	bundle_t             entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0]   wptr_q;
	logic [QUEUE_AW:0]   rptr_q;

	assign head_valid = (wptr_q != rptr_q);
	assign full = (wptr_q[QUEUE_AW] != rptr_q[QUEUE_AW]) &&
		(wptr_q[QUEUE_AW-1:0] == rptr_q[QUEUE_AW-1:0]);
	assign head = entries_q[rptr_q[QUEUE_AW-1:0]];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entries_q[wptr_q[QUEUE_AW-1:0]] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push_valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/rtpnal_back.sv */
// back part: walks each bundle and presents its events through an output register
module rtpnal_back import rtpnal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bundle_t           head,
	input  logic              head_valid,
	output logic              pop,
	output logic              event_valid,
	input  logic              event_ready,
	output logic [1:0]        event_kind,
	output logic [LEN_W-1:0]  store_address,
	output logic [7:0]        store_data,
	output logic [LEN_W-1:0]  nal_length,
	output logic [TS_W-1:0]   nal_timestamp,
	output logic [TYPE_W-1:0] nal_type,
	output logic              last_of_run
);

	logic [COUNT_W-1:0] idx_q;
	logic               out_valid_q;
	event_t             out_ev_q;
	logic               out_last_q;
	logic               load;
	logic               last;

	assign load = head_valid && (!out_valid_q || event_ready);
	assign last = (idx_q == head.count - 1'b1);
	assign pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (event_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ev_q <= head.ev[idx_q];
			out_last_q <= last;
		end
	end

	assign event_valid = out_valid_q;
	assign event_kind = out_ev_q.kind;
	assign store_address = out_ev_q.addr;
	assign store_data = out_ev_q.data;
	assign nal_length = out_ev_q.len;
	assign nal_timestamp = out_ev_q.ts;
	assign nal_type = out_ev_q.typ;
	assign last_of_run = out_last_q;

endmodule

/* rtl/rtp_h264_nal_reassembler.sv */
// top level of the rtp h.264 nal reassembler
// Takes one RTP payload byte per cycle while the queue has room and emits
// store-byte, NAL-complete, drop and packet-error events. The front part
// classifies each byte in the cycle it is taken and writes the one to three
// events it causes, if any, as one bundle into a four-entry queue; the back
// part sends one event per cycle while event_ready is high, through an
// output register. Bytes that cause at most one event thus stream at one
// per cycle while event_ready is high; a byte that causes several events
// holds the back part until all are sent, and the queue absorbs short
// bursts of those. The capacity register may be written at any time the
// block is idle; there is no clearing pass after reset.
module rtp_h264_nal_reassembler import rtpnal_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [7:0]        payload_byte,
	input  logic              packet_start,
	input  logic              packet_end,
	input  logic [LEN_W-1:0]  packet_length,
	input  logic [TS_W-1:0]   rtp_timestamp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data,
	output logic              event_valid,
	input  logic              event_ready,
	output logic [1:0]        event_kind,
	output logic [LEN_W-1:0]  store_address,
	output logic [7:0]        store_data,
	output logic [LEN_W-1:0]  nal_length,
	output logic [TS_W-1:0]   nal_timestamp,
	output logic [TYPE_W-1:0] nal_type,
	output logic              last_of_run
);

	logic    push_valid;
	bundle_t push_bundle;
	logic    queue_full;
	logic    pop;
	bundle_t head;
	logic    head_valid;

	assign item_ready = !queue_full;
	assign cfg_ready = 1'b1;

	rtpnal_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.payload_byte(payload_byte),
		.packet_start(packet_start),
		.packet_end(packet_end),
		.packet_length(packet_length),
		.rtp_timestamp(rtp_timestamp),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.push_valid(push_valid),
		.push_bundle(push_bundle)
	);

	rtpnal_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_bundle(push_bundle),
		.full(queue_full),
		.pop(pop),
		.head(head),
		.head_valid(head_valid)
	);

	rtpnal_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_kind(event_kind),
		.store_address(store_address),
		.store_data(store_data),
		.nal_length(nal_length),
		.nal_timestamp(nal_timestamp),
		.nal_type(nal_type),
		.last_of_run(last_of_run)
	);

endmodule

/* rtl/rtpnal_checker.sv */
// port-level assertions for the nal reassembler and their bind
`include "assert_macros.svh"

module rtpnal_checker import rtpnal_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              event_valid,
	input logic              event_ready,
	input logic [1:0]        event_kind,
	input logic [LEN_W-1:0]  store_address,
	input logic [7:0]        store_data,
	input logic [LEN_W-1:0]  nal_length,
	input logic [TS_W-1:0]   nal_timestamp,
	input logic              last_of_run
);

	`RTPNAL_ASSERT_NEXT(a_valid_holds, clk, arst_n, event_valid && !event_ready, event_valid, "event valid dropped before transfer")
	`RTPNAL_ASSERT_NEXT(a_payload_holds, clk, arst_n, event_valid && !event_ready, $stable(event_kind) && $stable(store_address) && $stable(store_data) && $stable(nal_length), "event payload changed while stalled")
	`RTPNAL_ASSERT(a_store_clean, clk, arst_n, !(event_valid && event_kind == EV_STORE) || (nal_length == '0 && nal_timestamp == '0), "store event carries nal length or timestamp")
	`RTPNAL_ASSERT(a_final_last, clk, arst_n, !(event_valid && (event_kind == EV_COMPLETE || event_kind == EV_ERROR)) || last_of_run, "complete or error event not last of its run")

endmodule

bind rtp_h264_nal_reassembler rtpnal_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.event_valid(event_valid),
	.event_ready(event_ready),
	.event_kind(event_kind),
	.store_address(store_address),
	.store_data(store_data),
	.nal_length(nal_length),
	.nal_timestamp(nal_timestamp),
	.last_of_run(last_of_run)
);

/* dv/tb.sv */
// self-checking testbench for the rtp h.264 nal reassembler
`timescale 1ns / 1ps

module tb;
	import rtpnal_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 45;
	localparam logic [LEN_W-1:0] CAP_MAX = 16'hFFFF;
	localparam logic [LEN_W-1:0] TRUE_LEN = 16'd0;
	localparam logic [TYPE_W-1:0] TYPE_MTAP16 = 5'd26;

	typedef struct {
		event_kind_t      kind;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic [TS_W-1:0]  ts;
		logic [TYPE_W-1:0] typ;
		logic             last;
	} nal_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [7:0]        payload_byte = '0;
	logic              packet_start = 1'b0;
	logic              packet_end = 1'b0;
	logic [LEN_W-1:0]  packet_length = '0;
	logic [TS_W-1:0]   rtp_timestamp = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data = '0;
	logic              event_valid;
	logic              event_ready = 1'b0;
	logic [1:0]        event_kind;
	logic [LEN_W-1:0]  store_address;
	logic [7:0]        store_data;
	logic [LEN_W-1:0]  nal_length;
	logic [TS_W-1:0]   nal_timestamp;
	logic [TYPE_W-1:0] nal_type;
	logic              last_of_run;

	rtp_h264_nal_reassembler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.payload_byte  (payload_byte),
		.packet_start  (packet_start),
		.packet_end    (packet_end),
		.packet_length (packet_length),
		.rtp_timestamp (rtp_timestamp),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.event_valid   (event_valid),
		.event_ready   (event_ready),
		.event_kind    (event_kind),
		.store_address (store_address),
		.store_data    (store_data),
		.nal_length    (nal_length),
		.nal_timestamp (nal_timestamp),
		.nal_type      (nal_type),
		.last_of_run   (last_of_run)
	);

	// reassembly state mirrored from the byte stream
	logic [LEN_W-1:0]  cap_reg = CAP_MAX;
	logic              nal_open_q = 1'b0;
	logic [LEN_W-1:0]  wr_off = '0;
	logic [TS_W-1:0]   held_ts = '0;
	logic [LEN_W-1:0]  byte_pos = '0;
	logic [TYPE_W-1:0] pkt_kind = '0;
	logic [1:0]        skip_n = SKIP_NONE;
	logic [2:0]        ind_bits = '0;
	logic              pkt_completes = 1'b0;
	logic              pkt_discard = 1'b0;
	logic [TYPE_W-1:0] cur_type = '0;

	nal_event_t expected_events[$];
	nal_event_t step_events[$];
	logic [7:0] pkt_bytes[$];
	logic [TS_W-1:0] last_stamp = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int accepted_items = 0;
	int mismatches = 0;
	int cycle_count = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rtp_h264_nal_reassembler test failed");
			$finish;
		end
	end

	function automatic void add_event(event_kind_t k, logic [LEN_W-1:0] a, logic [7:0] d,
			logic [LEN_W-1:0] l, logic [TS_W-1:0] t);
		nal_event_t e;
		if (step_events.size() < MAX_RESULTS) begin
			e.kind = k;
			e.addr = a;
			e.data = d;
			e.len = l;
			e.ts = t;
			e.typ = cur_type;
			e.last = 1'b0;
			step_events.push_back(e);
		end
	endfunction

	function automatic void drop_nal(event_kind_t k);
		add_event(k, '0, '0, nal_open_q ? wr_off : '0, nal_open_q ? held_ts : '0);
		nal_open_q = 1'b0;
	endfunction

	function automatic void open_nal(logic [TS_W-1:0] stamp);
		if (!nal_open_q || held_ts != stamp) begin
			if (nal_open_q) drop_nal(EV_DROP);
			nal_open_q = 1'b1;
			wr_off = '0;
		end
		held_ts = stamp;
	endfunction

	function automatic bit room_ok(logic [LEN_W-1:0] need);
		logic [LEN_W-1:0] room;
		room = (cap_reg > wr_off) ? cap_reg - wr_off : '0;
		if (need > room) begin
			drop_nal(EV_DROP);
			pkt_discard = 1'b1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void store_byte(logic [7:0] b);
		if (!nal_open_q || pkt_discard) return;
		if (wr_off >= cap_reg) begin
			drop_nal(EV_DROP);
			pkt_discard = 1'b1;
			return;
		end
		add_event(EV_STORE, wr_off, b, '0, '0);
		wr_off = wr_off + 1'b1;
	endfunction

	function automatic void predict_events(logic [7:0] b, logic ps, logic pe,
			logic [LEN_W-1:0] len, logic [TS_W-1:0] stamp);
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] need;
		logic [LEN_W-1:0] hdr_n;
		bit fu;
		step_events.delete();
		pos = ps ? '0 : byte_pos;
		if (pos == 0) begin
			pkt_discard = 1'b0;
			pkt_completes = 1'b0;
			pkt_kind = b[TYPE_W-1:0];
			fu = (pkt_kind == TYPE_FU_A) || (pkt_kind == TYPE_FU_B);
			if (fu) begin
				ind_bits = b[7:5];
				skip_n = SKIP_FU;
				if (len < 2 || pe) begin
					drop_nal(EV_ERROR);
					pkt_discard = 1'b1;
				end else begin
					open_nal(stamp);
				end
			end else begin
				if (pkt_kind == TYPE_STAP_A) skip_n = SKIP_STAP_A;
				else if (pkt_kind >= TYPE_STAP_B && pkt_kind <= TYPE_MTAP24) skip_n = SKIP_LONG;
				else skip_n = SKIP_NONE;
				open_nal(stamp);
				cur_type = pkt_kind;
				pkt_completes = 1'b1;
				need = (len > LEN_W'(skip_n)) ? len - LEN_W'(skip_n) : '0;
				if (room_ok(need) && skip_n == SKIP_NONE) store_byte(b);
			end
		end else begin
			fu = (pkt_kind == TYPE_FU_A) || (pkt_kind == TYPE_FU_B);
			if (fu && pos == 1) begin
				if (!pkt_discard) begin
					hdr_n = b[FU_START_BIT] ? 16'd1 : 16'd2;
					need = (len > hdr_n) ? len - hdr_n : '0;
					pkt_completes = b[FU_END_BIT];
					cur_type = b[TYPE_W-1:0];
					if (room_ok(need) && b[FU_START_BIT]) store_byte({ind_bits, b[TYPE_W-1:0]});
				end
			end else if (pos >= LEN_W'(skip_n)) begin
				store_byte(b);
			end
		end
		if (pe) begin
			if (!pkt_discard && nal_open_q && pkt_completes) begin
				add_event(EV_COMPLETE, '0, '0, wr_off, held_ts);
				nal_open_q = 1'b0;
			end
			byte_pos = '0;
		end else begin
			byte_pos = (pos < 16'hFFFF) ? pos + 1'b1 : pos;
		end
		if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i]) expected_events.push_back(step_events[i]);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// event sink: random stalls, long hold-off on request, and checking
	always @(posedge clk) begin : event_check
		nal_event_t want;
		if (arst_n && event_valid && event_ready) begin
			if (expected_events.size() == 0) begin
				$error("event_kind: expected none, got %0h", event_kind);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				check_field("event_kind", want.kind, event_kind);
				check_field("store_address", want.addr, store_address);
				check_field("store_data", want.data, store_data);
				check_field("nal_length", want.len, nal_length);
				check_field("nal_timestamp", want.ts, nal_timestamp);
				check_field("nal_type", want.typ, nal_type);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			event_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			event_ready <= 1'b0;
		end else begin
			event_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic ps, input logic pe,
			input logic [LEN_W-1:0] len, input logic [TS_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		payload_byte <= b;
		packet_start <= ps;
		packet_end <= pe;
		packet_length <= len;
		rtp_timestamp <= stamp;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		accepted_items++;
		predict_events(b, ps, pe, len, stamp);
	endtask

	task automatic send_packet(input logic [LEN_W-1:0] len_claim, input logic [TS_W-1:0] stamp,
			input bit mark_start, input bit mark_end);
		logic [LEN_W-1:0] len;
		len = (len_claim == TRUE_LEN) ? LEN_W'(pkt_bytes.size()) : len_claim;
		foreach (pkt_bytes[i])
			send_byte(pkt_bytes[i], (i == 0) && mark_start,
				(i == pkt_bytes.size() - 1) && mark_end, len, stamp);
		last_stamp = stamp;
	endtask

	function automatic void build_plain(logic [7:0] first, int body_len);
		pkt_bytes.delete();
		pkt_bytes.push_back(first);
		repeat (body_len) pkt_bytes.push_back(8'($urandom()));
	endfunction

	function automatic void build_fu(bit fu_b, logic [2:0] nri, bit start, bit stop,
			logic [TYPE_W-1:0] ntype, int body_len);
		pkt_bytes.delete();
		pkt_bytes.push_back({nri, fu_b ? TYPE_FU_B : TYPE_FU_A});
		pkt_bytes.push_back({start, stop, 1'($urandom()), ntype});
		repeat (body_len) pkt_bytes.push_back(8'($urandom()));
	endfunction

	task automatic settle_stream();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [LEN_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = value;
		@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_single_units();
		build_plain(8'h00, 0);
		send_packet(TRUE_LEN, 32'h0000_0000, 1'b1, 1'b1);
		build_plain(8'hFF, 2);
		send_packet(TRUE_LEN, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// start implied by the end of the previous packet
		build_plain(8'h65, 1);
		send_packet(TRUE_LEN, 32'h1234_5678, 1'b0, 1'b1);
	endtask

	task automatic test_aggregation();
		logic [TYPE_W-1:0] t;
		for (t = TYPE_STAP_A; t <= TYPE_MTAP24; t++) begin
			build_plain({3'b011, t}, 2);
			send_packet(TRUE_LEN, 32'(t), 1'b1, 1'b1);
		end
		// no longer than the aggregation header
		build_plain({3'b000, TYPE_STAP_A}, 0);
		send_packet(TRUE_LEN, 32'h100, 1'b1, 1'b1);
		build_plain({3'b000, TYPE_MTAP16}, 1);
		send_packet(TRUE_LEN, 32'h101, 1'b1, 1'b1);
	endtask

	task automatic test_fragments();
		build_fu(1'b0, 3'b011, 1'b1, 1'b0, 5'd5, 2);
		send_packet(TRUE_LEN, 32'hA000_0000, 1'b1, 1'b1);
		build_fu(1'b0, 3'b011, 1'b0, 1'b0, 5'd5, 1);
		send_packet(TRUE_LEN, 32'hA000_0000, 1'b1, 1'b1);
		build_fu(1'b0, 3'b011, 1'b0, 1'b1, 5'd5, 1);
		send_packet(TRUE_LEN, 32'hA000_0000, 1'b1, 1'b1);
		build_fu(1'b1, 3'b100, 1'b1, 1'b1, 5'd1, 1);
		send_packet(TRUE_LEN, 32'hB000_0000, 1'b1, 1'b1);
		// short fragments
		build_plain({3'b011, TYPE_FU_A}, 0);
		send_packet(TRUE_LEN, 32'hB000_0001, 1'b1, 1'b1);
		build_plain({3'b011, TYPE_FU_B}, 0);
		send_packet(16'd4, 32'hB000_0002, 1'b1, 1'b1);
		build_fu(1'b0, 3'b001, 1'b1, 1'b1, 5'd1, 1);
		send_packet(16'd1, 32'hB000_0003, 1'b1, 1'b1);
		// stale nal replaced by a new timestamp
		build_fu(1'b0, 3'b010, 1'b1, 1'b0, 5'd7, 1);
		send_packet(TRUE_LEN, 32'hC000_0000, 1'b1, 1'b1);
		build_plain(8'h41, 0);
		send_packet(TRUE_LEN, 32'hD000_0000, 1'b1, 1'b1);
		// same timestamp appends to the open nal
		build_fu(1'b0, 3'b010, 1'b1, 1'b0, 5'd8, 1);
		send_packet(TRUE_LEN, 32'hE000_0000, 1'b1, 1'b1);
		build_plain(8'h06, 1);
		send_packet(TRUE_LEN, 32'hE000_0000, 1'b1, 1'b1);
	endtask

	task automatic test_capacity();
		settle_stream();
		write_capacity(16'd1);
		build_plain(8'h41, 0);
		send_packet(TRUE_LEN, 32'h10, 1'b1, 1'b1);
		build_plain(8'h41, 1);
		send_packet(TRUE_LEN, 32'h11, 1'b1, 1'b1);
		// longer than its length claims
		build_plain(8'h41, 2);
		send_packet(16'd1, 32'h12, 1'b1, 1'b1);
		build_fu(1'b0, 3'b011, 1'b1, 1'b1, 5'd7, 1);
		send_packet(TRUE_LEN, 32'h13, 1'b1, 1'b1);
		settle_stream();
		write_capacity(CAP_MAX);
		build_fu(1'b0, 3'b010, 1'b1, 1'b0, 5'd1, 4);
		send_packet(TRUE_LEN, 32'h14, 1'b1, 1'b1);
		// capacity lowered below the open nal
		settle_stream();
		write_capacity(16'd2);
		build_fu(1'b0, 3'b010, 1'b0, 1'b1, 5'd1, 1);
		send_packet(TRUE_LEN, 32'h14, 1'b1, 1'b1);
		settle_stream();
		write_capacity(CAP_MAX);
	endtask

	task automatic send_random_packet();
		int pick;
		int frags;
		bit fu_b;
		bit broken;
		logic [2:0] nri;
		logic [TYPE_W-1:0] ntype;
		logic [TS_W-1:0] stamp;
		pick = $urandom_range(99);
		if (pick < 40) begin
			stamp = $urandom();
			frags = $urandom_range(1, 4);
			fu_b = ($urandom_range(3) == 0);
			broken = ($urandom_range(9) == 0);
			nri = 3'($urandom());
			ntype = 5'($urandom_range(1, 23));
			for (int i = 0; i < frags; i++) begin
				build_fu(fu_b, nri, i == 0, (i == frags - 1) && !broken, ntype,
					$urandom_range(1, 4));
				if (broken && i == frags - 1 && $urandom_range(1)) stamp = $urandom();
				send_packet(TRUE_LEN, stamp, 1'b1, 1'b1);
			end
		end else if (pick < 60) begin
			ntype = 5'($urandom_range(0, 25));
			if (ntype >= TYPE_STAP_A) ntype = ntype + 5'd6;
			build_plain({3'($urandom()), ntype}, $urandom_range(0, 5));
			send_packet(TRUE_LEN, $urandom_range(1) ? last_stamp : $urandom(), 1'b1, 1'b1);
		end else if (pick < 72) begin
			ntype = 5'($urandom_range(TYPE_STAP_A, TYPE_MTAP24));
			build_plain({3'($urandom()), ntype}, $urandom_range(0, 6));
			send_packet(TRUE_LEN, $urandom(), 1'b1, 1'b1);
		end else begin
			build_plain(8'($urandom()), $urandom_range(0, 4));
			send_packet($urandom_range(1) ? TRUE_LEN : 16'($urandom_range(1, 65535)),
				$urandom_range(1) ? last_stamp : $urandom(),
				$urandom_range(3) != 0, $urandom_range(3) != 0);
		end
	endtask

	task automatic test_random_traffic(input int goal, input logic [LEN_W-1:0] cap,
			input bit with_hold);
		int start_count;
		settle_stream();
		write_capacity(cap);
		if (with_hold) hold_req <= ~hold_req;
		start_count = accepted_items;
		while (accepted_items - start_count < goal) send_random_packet();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(33, 61);
		test_single_units();
		test_aggregation();
		test_fragments();
		test_capacity();
		test_random_traffic(PHASE_ITEMS, CAP_MAX, 1'b0);
		set_idling(61, 33);
		test_random_traffic(PHASE_ITEMS, 16'($urandom_range(4, 40)), 1'b0);
		set_idling(0, 0);
		test_random_traffic(PHASE_ITEMS, 16'($urandom_range(24, 300)), 1'b1);
		settle_stream();
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("rtp_h264_nal_reassembler test passed");
		end else begin
			$display("rtp_h264_nal_reassembler test failed");
		end
		$finish;
	end

endmodule
